[rtl/core/sam_pkg.sv]
// ----------------------------------------------------------------------------
// sam_pkg
// Types and request codes shared by the sub-anagram match chain.
// ----------------------------------------------------------------------------
package sam_pkg;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_WORD  = 2'd2
   } req_kind_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] letter;
      logic       last;
   } req_beat_type;

   typedef struct packed {
      logic        matched;
      logic [15:0] word_index;
      logic        user_overflow;
   } rsp_beat_type;

   // One slot of the chain. pending: an add still looks for a free cell,
   // a word letter still looks for an unclaimed user letter.
   typedef struct packed {
      logic         valid;
      req_kind_type kind;
      logic [7:0]   letter;
      logic         last;
      logic         pending;
   } sam_token_type;

   localparam logic [15:0] WORD_INDEX_MAX = 16'hFFFF;

endpackage

[rtl/core/sam_cell.sv]
// ----------------------------------------------------------------------------
// sam_cell
// One chain cell: holds one user letter and its claim flag for the current
// word, and passes a token on to the next cell every cycle that the chain advances.
// ----------------------------------------------------------------------------
module sam_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  sam_pkg::sam_token_type tok_in,
   output sam_pkg::sam_token_type tok_out
);
   import sam_pkg::*;

   logic          user_vld_ff, user_vld_in;
   logic [7:0]    user_letter_ff, user_letter_in;
   logic          claimed_ff, claimed_in;
   sam_token_type tok_ff, tok_in_next;
   logic          hit;
   logic          fill;

   assign hit  = tok_in.valid && (tok_in.kind == REQ_WORD) && tok_in.pending &&
                 user_vld_ff && !claimed_ff && (user_letter_ff == tok_in.letter);
   assign fill = tok_in.valid && (tok_in.kind == REQ_ADD) && tok_in.pending &&
                 !user_vld_ff;

   always_comb begin
      user_vld_in         = user_vld_ff;
      user_letter_in      = user_letter_ff;
      claimed_in          = claimed_ff;
      tok_in_next         = tok_in;
      tok_in_next.pending = tok_in.pending && !(hit || fill);
      if (tok_in.valid) begin
         case (tok_in.kind)
            REQ_CLEAR: begin
               user_vld_in = 1'b0;
               claimed_in  = 1'b0;
            end
            REQ_ADD: begin
               if (fill) begin
                  user_vld_in    = 1'b1;
                  user_letter_in = tok_in.letter;
                  claimed_in     = 1'b0;
               end
            end
            REQ_WORD: begin
               // free the claim once the word's final letter has gone by
               if (tok_in.last) begin
                  claimed_in = 1'b0;
               end else if (hit) begin
                  claimed_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         user_vld_ff <= 1'b0;
         claimed_ff  <= 1'b0;
         tok_ff      <= '0;
      end else if (advance) begin
         user_vld_ff <= user_vld_in;
         claimed_ff  <= claimed_in;
         tok_ff      <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         user_letter_ff <= user_letter_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

[rtl/core/sam_tail.sv]
// ----------------------------------------------------------------------------
// sam_tail
// End of the chain: collects per-word failure, numbers the words, tracks
// user letter overflow and holds the response beat.
// ----------------------------------------------------------------------------
module sam_tail (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  sam_pkg::sam_token_type tok_in,
   output logic                   rsp_valid,
   output sam_pkg::rsp_beat_type  rsp_data
);
   import sam_pkg::*;

   logic         failed_ff, failed_in;
   logic [15:0]  word_num_ff, word_num_in;
   logic         overflow_ff, overflow_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_ff, rsp_in;
   logic         word_end;

   assign word_end = tok_in.valid && (tok_in.kind == REQ_WORD) && tok_in.last;

   always_comb begin
      failed_in            = failed_ff;
      word_num_in          = word_num_ff;
      overflow_in          = overflow_ff;
      rsp_in.matched       = !(failed_ff || tok_in.pending);
      rsp_in.word_index    = word_num_ff;
      rsp_in.user_overflow = overflow_ff;
      rsp_valid_in         = word_end;
      if (tok_in.valid) begin
         case (tok_in.kind)
            REQ_CLEAR: begin
               failed_in   = 1'b0;
               word_num_in = '0;
               overflow_in = 1'b0;
            end
            REQ_ADD: begin
               // an add that found no free cell fell off the end
               if (tok_in.pending) begin
                  overflow_in = 1'b1;
               end
            end
            REQ_WORD: begin
               if (tok_in.last) begin
                  failed_in = 1'b0;
                  if (word_num_ff != WORD_INDEX_MAX) begin
                     word_num_in = word_num_ff + 16'd1;
                  end
               end else begin
                  failed_in = failed_ff || tok_in.pending;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         failed_ff    <= 1'b0;
         word_num_ff  <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         failed_ff    <= failed_in;
         word_num_ff  <= word_num_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && word_end) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/sub_anagram_match.sv]
// A word's response comes through the MAX_LETTERS cell registers and the tail register.
// One request beat per cycle unless held; each beat moves one cell per cycle down the chain.
// The whole chain holds only while a response beat waits under rsp_stall.
// Reset empties all cells, the word count and the overflow flag; no clearing pass.
// ----------------------------------------------------------------------------
// sub_anagram_match
// Letter-multiset containment: user letters sit one per cell, word letters
// travel the chain and claim a matching free cell; an unclaimed letter fails.
// ----------------------------------------------------------------------------
module sub_anagram_match #(
   parameter int MAX_LETTERS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sam_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sam_pkg::rsp_beat_type rsp_data
);
   import sam_pkg::*;

   logic          advance;
   logic          req_known;
   sam_token_type chain [MAX_LETTERS+1];

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // drop the unused request code at the door
   assign req_known = (req_data.req_type == REQ_CLEAR) ||
                      (req_data.req_type == REQ_ADD)   ||
                      (req_data.req_type == REQ_WORD);

   assign chain[0] = '{valid:   req_valid && req_known,
                       kind:    req_kind_type'(req_data.req_type),
                       letter:  req_data.letter,
                       last:    req_data.last,
                       pending: 1'b1};

   for (genvar i = 0; i < MAX_LETTERS; i++) begin : g_cell
      sam_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end

   sam_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .tok_in    (chain[MAX_LETTERS]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/sam_checker.sv]
// ----------------------------------------------------------------------------
// sam_checker
// Port-level checks on the sub-anagram match block.
// ----------------------------------------------------------------------------
module sam_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input sam_pkg::req_beat_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input sam_pkg::rsp_beat_type rsp_data
);
   import sam_pkg::*;

   // a stalled response beat stays up and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response beat dropped or changed under stall");

   // a blocked response backs up into the request side
   a_back_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response is blocked");

   // reset leaves no response beat behind
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // with no response beat up, the request side is never stalled
   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty response slot");

endmodule

bind sub_anagram_match sam_checker u_sam_checker (.*);
